[hdl/b64enc_pkg.sv]
// Shared types, constants and the alphabet lookup for the Base64 stream encoder.
`timescale 1ns / 1ps

package b64enc_pkg;

    // Number of group entries buffered between the front and back parts
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam logic [5:0] SIX_MASK = 6'h3F;

    // Count of pending bytes in a group
    localparam logic [1:0] POS_EMPTY = 2'd0;
    localparam logic [1:0] POS_ONE   = 2'd1;
    localparam logic [1:0] POS_TWO   = 2'd2;

    // Character slot inside a four-character group
    localparam logic [1:0] SLOT_LAST = 2'd3;
    localparam logic [1:0] SLOT_PAD1 = 2'd2;

    // One group ready for output: 24-bit word, bytes that were pending before
    // the closing byte (0..2), and whether that byte ended the message
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  pos;
        logic        fin;
    } group_t;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
    function automatic logic [7:0] b64_char(input logic [5:0] sextet);
        logic [7:0] code;
        code = {2'b00, sextet};
        case (sextet) inside
            [6'd0 : 6'd25]:  b64_char = code + 8'd65;
            [6'd26 : 6'd51]: b64_char = code + 8'd71;
            [6'd52 : 6'd61]: b64_char = code - 8'd4;
            6'd62:           b64_char = 8'h2B;
            default:         b64_char = 8'h2F;
        endcase
    endfunction

endpackage

[hdl/b64enc_front.sv]
// Front part: accepts bytes, holds partial groups and emits completed groups.
`timescale 1ns / 1ps

module b64enc_front
    import b64enc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_final_byte,
    input  logic        q_full,
    output logic        q_push,
    output group_t      q_group
);

    logic [15:0] held_reg,  held_next;
    logic [1:0]  pos_reg,   pos_next;
    logic [1:0]  pos_eff;
    logic        accept;
    logic        closes;

    // Unused position code is treated as an empty group
    always_comb begin
        case (pos_reg)
            POS_ONE: pos_eff = POS_ONE;
            POS_TWO: pos_eff = POS_TWO;
            default: pos_eff = POS_EMPTY;
        endcase
    end

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign closes  = s_final_byte || (pos_eff == POS_TWO);
    assign q_push  = accept && closes;

    // Assemble the group word from held bytes and the closing byte
    always_comb begin
        q_group.pos = pos_eff;
        q_group.fin = s_final_byte;
        case (pos_eff)
            POS_ONE: q_group.word = {held_reg[15:8], s_data_byte, 8'h00};
            POS_TWO: q_group.word = {held_reg, s_data_byte};
            default: q_group.word = {s_data_byte, 16'h0000};
        endcase
    end

    // Hold state update
    always_comb begin
        held_next = held_reg;
        pos_next  = pos_reg;
        if (accept) begin
            if (closes) begin
                held_next = 16'h0000;
                pos_next  = POS_EMPTY;
            end else if (pos_eff == POS_EMPTY) begin
                held_next = {s_data_byte, 8'h00};
                pos_next  = POS_ONE;
            end else begin
                held_next = {held_reg[15:8], s_data_byte};
                pos_next  = POS_TWO;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= 16'h0000;
            pos_reg  <= POS_EMPTY;
        end else begin
            held_reg <= held_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

[hdl/b64enc_queue.sv]
// Short queue of completed groups between the front and back parts.
`timescale 1ns / 1ps

module b64enc_queue
    import b64enc_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  group_t push_group,
    output logic   full,
    input  logic   pop,
    output group_t pop_group,
    output logic   empty
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);

    group_t          entries [Depth];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;
    logic            do_push, do_pop;

    assign full      = (count_reg == CW'(Depth));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_group = entries[rd_ptr_reg];

    // Pointer and count update with wrap at the depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_group;
        end
    end

endmodule

[hdl/b64enc_back.sv]
// Back part: turns one group into four output characters, one per cycle while m_ready is high.
`timescale 1ns / 1ps

module b64enc_back
    import b64enc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_empty,
    input  group_t      q_group,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_char,
    output logic        m_run_end,
    output logic        m_text_end
);

    group_t      grp_reg,       grp_next;
    logic        grp_valid_reg, grp_valid_next;
    logic [1:0]  slot_reg,      slot_next;
    logic        m_valid_reg,   m_valid_next;
    logic [7:0]  char_reg,      char_next;
    logic        run_end_reg,   run_end_next;
    logic        text_end_reg,  text_end_next;
    logic        load;
    logic        grp_done;
    logic [5:0]  sextet;

    assign m_valid    = m_valid_reg;
    assign m_out_char = char_reg;
    assign m_run_end  = run_end_reg;
    assign m_text_end = text_end_reg;

    // Move a character into the output register when it is free or draining
    assign load     = grp_valid_reg && (!m_valid_reg || m_ready);
    assign grp_done = load && (slot_reg == SLOT_LAST);
    assign q_pop    = !q_empty && (!grp_valid_reg || grp_done);

    // Sextet for the current slot
    always_comb begin
        case (slot_reg)
            2'd0:    sextet = grp_reg.word[23:18] & SIX_MASK;
            2'd1:    sextet = grp_reg.word[17:12] & SIX_MASK;
            2'd2:    sextet = grp_reg.word[11:6]  & SIX_MASK;
            default: sextet = grp_reg.word[5:0]   & SIX_MASK;
        endcase
    end

    // Character, padding and end flags for the current slot
    always_comb begin
        char_next     = char_reg;
        run_end_next  = run_end_reg;
        text_end_next = text_end_reg;
        m_valid_next  = m_valid_reg;
        if (load) begin
            if ((slot_reg == SLOT_PAD1) && (grp_reg.pos == POS_EMPTY)) begin
                char_next = PAD_CHAR;
            end else if ((slot_reg == SLOT_LAST) && (grp_reg.pos != POS_TWO)) begin
                char_next = PAD_CHAR;
            end else begin
                char_next = b64_char(sextet);
            end
            run_end_next  = (slot_reg == SLOT_LAST);
            text_end_next = (slot_reg == SLOT_LAST) && grp_reg.fin;
            m_valid_next  = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Group register and slot counter
    always_comb begin
        grp_next       = grp_reg;
        grp_valid_next = grp_valid_reg;
        slot_next      = slot_reg;
        if (load) begin
            slot_next = slot_reg + 1'b1;
        end
        if (grp_done) begin
            grp_valid_next = 1'b0;
        end
        if (q_pop) begin
            grp_next       = q_group;
            grp_valid_next = 1'b1;
            slot_next      = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_valid_reg <= 1'b0;
            slot_reg      <= 2'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            grp_valid_reg <= grp_valid_next;
            slot_reg      <= slot_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        grp_reg      <= grp_next;
        char_reg     <= char_next;
        run_end_reg  <= run_end_next;
        text_end_reg <= text_end_next;
    end

endmodule

[hdl/base64_stream_encoder.sv]
// Top level of the Base64 stream encoder: front, group queue and back part.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_valid/s_ready    s_data_byte[7:0], s_final_byte
// m_*       out  m_valid/m_ready    m_out_char[7:0], m_run_end, m_text_end
//
// A byte is taken when s_valid and s_ready are both high; bytes that close a group
// (third byte or final byte) push a group into a QueueDepth-entry queue. The back part
// emits four characters per group at one per cycle while m_ready is high, so the result
// port sets the rate: sustained input is three bytes per four characters for full groups.
// Synchronous active-low reset clears held bytes, queue and output valid.
// s_ready drops only when the group queue is full; m_ready low stalls the back.
`timescale 1ns / 1ps

module base64_stream_encoder
    import b64enc_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_final_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_char,
    output logic        m_run_end,
    output logic        m_text_end
);

    group_t push_group;
    group_t pop_group;
    logic   q_push, q_pop, q_full, q_empty;

    b64enc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_final_byte (s_final_byte),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_group      (push_group)
    );

    b64enc_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_group (push_group),
        .full       (q_full),
        .pop        (q_pop),
        .pop_group  (pop_group),
        .empty      (q_empty)
    );

    b64enc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_group    (pop_group),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_run_end  (m_run_end),
        .m_text_end (m_text_end)
    );

endmodule

[tb/tb.sv]
// Self-checking testbench for the Base64 stream encoder.
`timescale 1ns / 1ps

module tb
    import b64enc_pkg::*;
;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 6;
    // A slow correct run stays far below this limit
    localparam int CYCLE_LIMIT  = 300000;
    // Settle time once nothing is owed: covers the group queue and the output stage
    localparam int DRAIN_CYCLES = 16;
    localparam string B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // One encoded character as it should leave the block
    typedef struct packed {
        logic [7:0] ch;
        logic       run_end;
        logic       text_end;
    } enc_char_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte = 8'h00;
    logic       s_final_byte = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_char;
    logic       m_run_end;
    logic       m_text_end;

    // Predictor state: pending bytes and how many are held
    logic [15:0] held_pair = 16'h0000;
    logic [1:0]  held_count = POS_EMPTY;
    enc_char_t   owed_chars[$];
    enc_char_t   want_char;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count    = 0;
    int bytes_sent    = 0;
    int msgs_sent     = 0;
    int chars_checked = 0;
    int cycle_count   = 0;

    base64_stream_encoder dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_final_byte (s_final_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_char   (m_out_char),
        .m_run_end    (m_run_end),
        .m_text_end   (m_text_end)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Timeout watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Map one 6-bit field of the group word to its ASCII character
    function automatic logic [7:0] sextet_ascii(input logic [23:0] word, input int shift);
        logic [5:0] idx;
        idx = word[shift +: 6];
        return B64_ALPHABET[idx];
    endfunction

    // Advance the encoder state by one accepted byte and queue any characters it owes
    function automatic void encode_byte(input logic [7:0] b, input logic fin);
        logic [1:0]  pos;
        logic [23:0] word;
        logic [7:0]  chars[4];
        enc_char_t   c;
        pos = (held_count == 2'd3) ? POS_EMPTY : held_count;
        // Byte that neither completes a group nor ends the message is just held
        if (!fin && pos != POS_TWO) begin
            if (pos == POS_EMPTY)
                held_pair = {b, 8'h00};
            else
                held_pair[7:0] = b;
            held_count = pos + 2'd1;
            return;
        end
        case (pos)
            POS_EMPTY: word = {b, 16'h0000};
            POS_ONE:   word = {held_pair[15:8], b, 8'h00};
            default:   word = {held_pair, b};
        endcase
        chars[0] = sextet_ascii(word, 18);
        chars[1] = sextet_ascii(word, 12);
        chars[2] = (pos != POS_EMPTY) ? sextet_ascii(word, 6) : PAD_CHAR;
        chars[3] = (pos == POS_TWO) ? sextet_ascii(word, 0) : PAD_CHAR;
        for (int k = 0; k < 4; k++) begin
            c.ch       = chars[k];
            c.run_end  = (k == 3);
            c.text_end = (k == 3) && fin;
            owed_chars = {owed_chars, c};
        end
        held_pair  = 16'h0000;
        held_count = POS_EMPTY;
    endfunction

    // Receiver: random back-pressure, and check every character transaction
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            if (owed_chars.size() == 0) begin
                $error("unexpected character 0x%02h run_end=%0b text_end=%0b",
                       m_out_char, m_run_end, m_text_end);
                fail_count++;
            end else begin
                want_char = owed_chars.pop_front();
                chars_checked++;
                if (m_out_char !== want_char.ch) begin
                    $error("out_char: expected 0x%02h, got 0x%02h", want_char.ch, m_out_char);
                    fail_count++;
                end
                if (m_run_end !== want_char.run_end) begin
                    $error("run_end: expected %0b, got %0b", want_char.run_end, m_run_end);
                    fail_count++;
                end
                if (m_text_end !== want_char.text_end) begin
                    $error("text_end: expected %0b, got %0b", want_char.text_end, m_text_end);
                    fail_count++;
                end
            end
        end
    end

    // Send one byte; valid stays high back to back unless a random gap is taken
    task automatic send_byte(input logic [7:0] b, input logic fin);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid      <= 1'b1;
        s_data_byte  <= b;
        s_final_byte <= fin;
        do @(posedge aclk); while (!s_ready);
        encode_byte(b, fin);
        bytes_sent++;
        if (fin)
            msgs_sent++;
    endtask

    // Hold the sender off until every owed character has come out
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (owed_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // One- and two-byte messages: both padding forms, extreme byte values
    task automatic test_padding();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b1);
    endtask

    // Full groups: mid-message group, group closed by the final byte,
    // final byte that starts a fresh group
    task automatic test_full_groups();
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b0);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBE, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);
        wait_drained();
    endtask

    // Random messages, mostly short, a few long, some stray single bytes
    task automatic test_random(input int n_bytes, input int spct, input int rpct);
        int start;
        int len;
        logic [7:0] b;
        send_idle_pct = spct;
        recv_idle_pct = rpct;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            if ($urandom_range(9) == 0) begin
                send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
            end else begin
                len = ($urandom_range(7) == 0) ? $urandom_range(24, 10) : $urandom_range(9, 1);
                for (int i = 0; i < len; i++) begin
                    case ($urandom_range(7))
                        0:       b = 8'h00;
                        1:       b = 8'hFF;
                        default: b = 8'($urandom_range(255));
                    endcase
                    send_byte(b, i == len - 1);
                end
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 22;
        recv_idle_pct = 51;
        test_padding();
        test_full_groups();
        test_random(45, 22, 51);
        test_random(45, 51, 22);
        test_random(44, 0, 0);

        $display("Encoded %0d bytes in %0d messages; %0d characters checked.",
                 bytes_sent, msgs_sent, chars_checked);
        $display("Covered padding, full groups and random traffic under three stall mixes.");
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
